// ----- sv/bfcr_pkg.sv -----
// ----------------------------------------------------------------------------
// bfcr_pkg: shared definitions for the bitmap font console renderer
// Font geometry, derived widths, opcodes, register indexes and FSM states.
// ----------------------------------------------------------------------------
package bfcr_pkg;

    // Font store geometry
    localparam int GLYPH_COUNT    = 256;
    localparam int MAX_GLYPH_ROWS = 32;
    localparam int GLYPH_WIDTH    = 8;
    localparam int COORD_MAX      = 4095;
    localparam int NEWLINE_CODE   = 10;

    // Derived widths
    localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(MAX_GLYPH_ROWS);
    localparam int HEIGHT_W    = $clog2(MAX_GLYPH_ROWS + 1);

    // Input operations
    typedef enum logic [1:0] {
        OP_PUT_CHAR  = 2'd0,
        OP_SET_COL   = 2'd1,
        OP_SET_LINE  = 2'd2,
        OP_LOAD_ROW  = 2'd3
    } bfcr_op_t;

    // Configuration register indexes
    localparam logic [2:0] REG_CONSOLE_ENABLED  = 3'd0;
    localparam logic [2:0] REG_GLYPH_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_SCREEN_WIDTH     = 3'd2;
    localparam logic [2:0] REG_SCREEN_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_LINE_PITCH       = 3'd4;
    localparam logic [2:0] REG_FRAMEBUFFER_BASE = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_EMIT
    } bfcr_state_t;

endpackage

// ----- sv/bitmap_font_console_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_font_console_renderer_unit: text console glyph row renderer
// Loads glyph rows into a font store, tracks the cursor and turns each put
// character other than a newline, while the console is enabled, into one framebuffer row write per glyph row.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: put character, set cursor column/line, load glyph
//   row. m_* returns one row write per glyph row of a drawn character, with
//   last_row on the final row and the dirty edges valid for that character.
//   cfg_* writes the six control registers by index; cfg_ready is always high.
//   Cursor, line and load requests, newline puts and disabled puts return
//   nothing. A drawn character passes the ST_MUL (line * pitch multiply) and
//   ST_ADDR (start address add) states, then reads one row per cycle out of
//   the font store's read port while the output does not stall.
//   A new request is taken once all rows of the current character have been
//   read from the store; rows still in flight drain behind it.
//   When m_ready is low with a row held in the output register, the read stage
//   and the output register hold, and store reads stop until a slot frees up.
//   Reset clears the cursor, dirty edges and registers to their defaults; the
//   font store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_font_console_renderer_unit
    import bfcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_char_code,
    input  logic [11:0] s_position_value,
    input  logic [4:0]  s_glyph_row_index,
    input  logic [7:0]  s_glyph_row_bits,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_address,
    output logic [7:0]  m_row_pixels,
    output logic        m_last_row,
    output logic [12:0] m_dirty_right,
    output logic [12:0] m_dirty_bottom
);

    // Control registers
    logic        console_enabled_reg;
    logic [5:0]  glyph_height_reg;
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [16:0] line_pitch_reg;
    logic [31:0] framebuffer_base_reg;

    // Cursor and dirty area
    logic [11:0] cursor_column_reg, cursor_column_next;
    logic [11:0] cursor_line_reg,   cursor_line_next;
    logic [12:0] dirty_right_reg,   dirty_right_next;
    logic [12:0] dirty_bottom_reg,  dirty_bottom_next;

    // Font store
    logic [7:0]          glyph_store [STORE_DEPTH];
    logic [7:0]          store_rdata_reg;
    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic                store_re;
    logic [STORE_AW-1:0] store_raddr;

    // Sequencer and job
    bfcr_state_t         state_reg, state_next;
    logic [11:0]         job_col_reg;
    logic [11:0]         job_line_reg;
    logic [HEIGHT_W-1:0] job_h_reg;
    logic [7:0]          job_code_reg;
    logic                job_code_ok_reg;
    logic [12:0]         job_right_reg;
    logic [12:0]         job_bottom_reg;
    logic [28:0]         job_prod_reg;
    logic [31:0]         row_addr_reg;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic                row_is_last;

    // Read stage
    logic        rd_valid_reg;
    logic [31:0] rd_addr_reg;
    logic        rd_last_reg;
    logic        rd_zero_reg;
    logic [12:0] rd_right_reg;
    logic [12:0] rd_bottom_reg;

    // Output register
    logic        m_valid_reg;
    logic [31:0] m_addr_reg;
    logic [7:0]  m_pixels_reg;
    logic        m_last_reg;
    logic [12:0] m_right_reg;
    logic [12:0] m_bottom_reg;

    logic                s_accept;
    logic                out_load;
    logic                code_ok;
    logic                row_ok;
    logic                draw_start;
    logic [HEIGHT_W-1:0] h_used;
    logic [12:0]         col_plus;
    logic [12:0]         line_plus;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;

    // Clamp glyph height to the store's row range
    always_comb begin
        if (glyph_height_reg == 6'd0) begin
            h_used = HEIGHT_W'(1);
        end else if (int'(glyph_height_reg) > MAX_GLYPH_ROWS) begin
            h_used = HEIGHT_W'(MAX_GLYPH_ROWS);
        end else begin
            h_used = HEIGHT_W'(glyph_height_reg);
        end
    end

    assign code_ok   = (int'(s_char_code) < GLYPH_COUNT);
    assign row_ok    = (int'(s_glyph_row_index) < MAX_GLYPH_ROWS);
    assign col_plus  = 13'(cursor_column_reg) + 13'(GLYPH_WIDTH);
    assign line_plus = 13'(cursor_line_reg) + 13'(h_used);

    // Request decode: cursor and dirty area updates
    always_comb begin
        cursor_column_next = cursor_column_reg;
        cursor_line_next   = cursor_line_reg;
        dirty_right_next   = dirty_right_reg;
        dirty_bottom_next  = dirty_bottom_reg;
        draw_start         = 1'b0;
        store_we           = 1'b0;
        store_waddr = STORE_AW'(s_char_code) * STORE_AW'(MAX_GLYPH_ROWS)
                    + STORE_AW'(s_glyph_row_index);
        if (s_accept) begin
            unique case (bfcr_op_t'(s_opcode))
                OP_SET_COL:  cursor_column_next = s_position_value;
                OP_SET_LINE: cursor_line_next   = s_position_value;
                OP_LOAD_ROW: store_we = code_ok && row_ok;
                OP_PUT_CHAR: begin
                    if (console_enabled_reg) begin
                        // wrapped line advance; the column wrap below repeats the same advance
                        if (int'(s_char_code) == NEWLINE_CODE) begin
                            cursor_column_next = 12'd0;
                            if (line_plus >= screen_height_reg
                                    || int'(line_plus) > COORD_MAX) begin
                                cursor_line_next = 12'd0;
                            end else begin
                                cursor_line_next = line_plus[11:0];
                            end
                        end else begin
                            draw_start = 1'b1;
                            if (col_plus > dirty_right_reg) begin
                                dirty_right_next = col_plus;
                            end
                            if (line_plus > dirty_bottom_reg) begin
                                dirty_bottom_next = line_plus;
                            end
                            if (col_plus >= screen_width_reg
                                    || int'(col_plus) > COORD_MAX) begin
                                cursor_column_next = 12'd0;
                                if (line_plus >= screen_height_reg
                                        || int'(line_plus) > COORD_MAX) begin
                                    cursor_line_next = 12'd0;
                                end else begin
                                    cursor_line_next = line_plus[11:0];
                                end
                            end else begin
                                cursor_column_next = col_plus[11:0];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Row pipeline handshake
    assign out_load    = rd_valid_reg && (!m_valid_reg || m_ready);
    assign row_is_last = (HEIGHT_W'(row_cnt_reg) == job_h_reg - HEIGHT_W'(1));

    // Sequencer: next state and store read enable
    always_comb begin
        state_next  = state_reg;
        store_re    = 1'b0;
        store_raddr = '0;
        if (job_code_ok_reg) begin
            store_raddr = STORE_AW'(job_code_reg) * STORE_AW'(MAX_GLYPH_ROWS)
                        + STORE_AW'(row_cnt_reg);
        end
        unique case (state_reg)
            ST_IDLE: if (draw_start) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_EMIT;
            ST_EMIT: begin
                store_re = !rd_valid_reg || out_load;
                if (store_re && row_is_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers, cursor and dirty edges
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            console_enabled_reg  <= 1'b0;
            glyph_height_reg     <= 6'd16;
            screen_width_reg     <= 13'd1024;
            screen_height_reg    <= 13'd768;
            line_pitch_reg       <= 17'd4096;
            framebuffer_base_reg <= 32'd0;
            cursor_column_reg    <= 12'd0;
            cursor_line_reg      <= 12'd0;
            dirty_right_reg      <= 13'd0;
            dirty_bottom_reg     <= 13'd0;
        end else begin
            cursor_column_reg <= cursor_column_next;
            cursor_line_reg   <= cursor_line_next;
            dirty_right_reg   <= dirty_right_next;
            dirty_bottom_reg  <= dirty_bottom_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_CONSOLE_ENABLED:  console_enabled_reg  <= cfg_data[0];
                    REG_GLYPH_HEIGHT:     glyph_height_reg     <= cfg_data[5:0];
                    REG_SCREEN_WIDTH:     screen_width_reg     <= cfg_data[12:0];
                    REG_SCREEN_HEIGHT:    screen_height_reg    <= cfg_data[12:0];
                    REG_LINE_PITCH:       line_pitch_reg       <= cfg_data[16:0];
                    REG_FRAMEBUFFER_BASE: framebuffer_base_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Font store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (store_we) begin
            glyph_store[store_waddr] <= s_glyph_row_bits;
        end
        if (store_re) begin
            store_rdata_reg <= glyph_store[store_raddr];
        end
    end

    // Job capture, start address and per-row address walk
    always_ff @(posedge aclk) begin
        if (draw_start) begin
            job_col_reg     <= cursor_column_reg;
            job_line_reg    <= cursor_line_reg;
            job_h_reg       <= h_used;
            job_code_reg    <= s_char_code;
            job_code_ok_reg <= code_ok;
            job_right_reg   <= dirty_right_next;
            job_bottom_reg  <= dirty_bottom_next;
        end
        if (state_reg == ST_MUL) begin
            job_prod_reg <= 29'(job_line_reg) * 29'(line_pitch_reg);
        end
        if (state_reg == ST_ADDR) begin
            row_addr_reg <= framebuffer_base_reg + 32'(job_prod_reg)
                          + {18'd0, job_col_reg, 2'b00};
            row_cnt_reg  <= '0;
        end else if (store_re) begin
            row_addr_reg <= row_addr_reg + 32'(line_pitch_reg);
            row_cnt_reg  <= row_cnt_reg + ROW_W'(1);
        end
    end

    // Read stage tags travel with the store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (store_re) begin
            rd_valid_reg <= 1'b1;
        end else if (out_load) begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_re) begin
            rd_addr_reg   <= row_addr_reg;
            rd_last_reg   <= row_is_last;
            rd_zero_reg   <= !job_code_ok_reg;
            rd_right_reg  <= job_right_reg;
            rd_bottom_reg <= job_bottom_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_addr_reg   <= rd_addr_reg;
            m_pixels_reg <= rd_zero_reg ? 8'd0 : store_rdata_reg;
            m_last_reg   <= rd_last_reg;
            m_right_reg  <= rd_right_reg;
            m_bottom_reg <= rd_bottom_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_address = m_addr_reg;
    assign m_row_pixels    = m_pixels_reg;
    assign m_last_row      = m_last_reg;
    assign m_dirty_right   = m_right_reg;
    assign m_dirty_bottom  = m_bottom_reg;

endmodule

// ----- dv/bfcr_checker.sv -----
// ----------------------------------------------------------------------------
// bfcr_checker: row write predictor and scoreboard for the console renderer
// Watches the register, request and row write channels. Keeps its own copy of
// the registers, cursor, dirty edges and font store, works out the row writes
// of every accepted request and compares each accepted row write, field by
// field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module bfcr_checker
    import bfcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_char_code,
    input  logic [11:0] s_position_value,
    input  logic [4:0]  s_glyph_row_index,
    input  logic [7:0]  s_glyph_row_bits,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_pixel_address,
    input  logic [7:0]  m_row_pixels,
    input  logic        m_last_row,
    input  logic [12:0] m_dirty_right,
    input  logic [12:0] m_dirty_bottom,

    output int          mismatch_count,
    output int          rows_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] pixel_address;
        logic [7:0]  row_pixels;
        logic        last_row;
        logic [12:0] dirty_right;
        logic [12:0] dirty_bottom;
    } row_write_t;

    row_write_t  pending_writes[$];

    // Register copy
    logic        console_on;
    logic [5:0]  glyph_height;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [16:0] line_pitch;
    logic [31:0] fb_base;

    // Cursor, dirty area and font store copy
    logic [11:0] cursor_col;
    logic [11:0] cursor_line;
    logic [12:0] right_edge;
    logic [12:0] bottom_edge;
    logic [7:0]  font_rows [STORE_DEPTH];

    int          errors = 0;

    // Height in use: register clamped to 1..MAX_GLYPH_ROWS
    function automatic int rows_per_glyph(logic [5:0] height);
        if (height < 1)
            return 1;
        if (int'(height) > MAX_GLYPH_ROWS)
            return MAX_GLYPH_ROWS;
        return int'(height);
    endfunction

    // Line advance, wrapping to the top at the screen height or the coord limit
    task automatic next_text_line(int rows);
        int next;
        next = int'(cursor_line) + rows;
        if (next >= int'(screen_height) || next > COORD_MAX)
            next = 0;
        cursor_line = 12'(next);
    endtask

    task automatic write_register(logic [2:0] index, logic [31:0] data);
        case (index)
            REG_CONSOLE_ENABLED:  console_on    = data[0];
            REG_GLYPH_HEIGHT:     glyph_height  = data[5:0];
            REG_SCREEN_WIDTH:     screen_width  = data[12:0];
            REG_SCREEN_HEIGHT:    screen_height = data[12:0];
            REG_LINE_PITCH:       line_pitch    = data[16:0];
            REG_FRAMEBUFFER_BASE: fb_base       = data;
            default: ;
        endcase
    endtask

    // Apply one request and queue the row writes it produces
    task automatic render_request(logic [1:0] op, logic [7:0] code, logic [11:0] pos,
                                  logic [4:0] row_index, logic [7:0] row_bits);
        int         rows;
        int         col_next;
        row_write_t w;
        case (bfcr_op_t'(op))
            OP_SET_COL: cursor_col = pos;
            OP_SET_LINE: cursor_line = pos;
            OP_LOAD_ROW: begin
                if (int'(code) < GLYPH_COUNT && int'(row_index) < MAX_GLYPH_ROWS)
                    font_rows[int'(code) * MAX_GLYPH_ROWS + int'(row_index)] = row_bits;
            end
            OP_PUT_CHAR: begin
                if (console_on) begin
                    rows = rows_per_glyph(glyph_height);
                    if (code == NEWLINE_CODE) begin
                        next_text_line(rows);
                        cursor_col = '0;
                    end else begin
                        // dirty edges grow before the first row goes out
                        if (int'(cursor_col) + GLYPH_WIDTH > int'(right_edge))
                            right_edge = 13'(int'(cursor_col) + GLYPH_WIDTH);
                        if (int'(cursor_line) + rows > int'(bottom_edge))
                            bottom_edge = 13'(int'(cursor_line) + rows);
                        for (int r = 0; r < rows; r++) begin
                            w.pixel_address = fb_base
                                + (32'(cursor_line) + 32'(r)) * 32'(line_pitch)
                                + 32'(cursor_col) * 32'd4;
                            if (int'(code) < GLYPH_COUNT)
                                w.row_pixels = font_rows[int'(code) * MAX_GLYPH_ROWS + r];
                            else
                                w.row_pixels = '0;
                            w.last_row     = (r == rows - 1);
                            w.dirty_right  = right_edge;
                            w.dirty_bottom = bottom_edge;
                            pending_writes.push_back(w);
                        end
                        // cursor moves right, wrapping to the next text line
                        col_next = int'(cursor_col) + GLYPH_WIDTH;
                        if (col_next >= int'(screen_width) || col_next > COORD_MAX) begin
                            cursor_col = '0;
                            next_text_line(rows);
                        end else begin
                            cursor_col = 12'(col_next);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_row_write();
        row_write_t want;
        if (pending_writes.size() == 0) begin
            $error("unexpected row write: pixel_address %h", m_pixel_address);
            errors++;
        end else begin
            want = pending_writes.pop_front();
            if (m_pixel_address !== want.pixel_address) begin
                $error("pixel_address: expected %h, actual %h",
                       want.pixel_address, m_pixel_address);
                errors++;
            end
            if (m_row_pixels !== want.row_pixels) begin
                $error("row_pixels: expected %h, actual %h", want.row_pixels, m_row_pixels);
                errors++;
            end
            if (m_last_row !== want.last_row) begin
                $error("last_row: expected %b, actual %b", want.last_row, m_last_row);
                errors++;
            end
            if (m_dirty_right !== want.dirty_right) begin
                $error("dirty_right: expected %0d, actual %0d", want.dirty_right, m_dirty_right);
                errors++;
            end
            if (m_dirty_bottom !== want.dirty_bottom) begin
                $error("dirty_bottom: expected %0d, actual %0d",
                       want.dirty_bottom, m_dirty_bottom);
                errors++;
            end
        end
    endtask

    // Row writes are checked before the request of the same edge is predicted:
    // a row leaving now always belongs to an earlier request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            console_on    = 1'b0;
            glyph_height  = 6'd16;
            screen_width  = 13'd1024;
            screen_height = 13'd768;
            line_pitch    = 17'd4096;
            fb_base       = '0;
            cursor_col    = '0;
            cursor_line   = '0;
            right_edge    = '0;
            bottom_edge   = '0;
            pending_writes.delete();
        end else begin
            if (m_valid && m_ready)
                check_row_write();
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                render_request(s_opcode, s_char_code, s_position_value,
                               s_glyph_row_index, s_glyph_row_bits);
        end
        mismatch_count   <= errors;
        rows_outstanding <= pending_writes.size();
    end

endmodule

// ----- dv/tb_bitmap_font_console_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_bitmap_font_console_renderer_unit: console renderer testbench
// Drives register writes and console requests into the renderer: a directed
// pass over cursor wrap, newline, off-screen rows and field extremes, then
// random phases of glyph loads followed by puts, under several register
// settings and three idle patterns, with one long output stall. The checker
// beside the block predicts and compares every row write.
// ----------------------------------------------------------------------------
module tb_bitmap_font_console_renderer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bfcr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 37;

    logic        aclk;
    logic        aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [7:0]  s_char_code = '0;
    logic [11:0] s_position_value = '0;
    logic [4:0]  s_glyph_row_index = '0;
    logic [7:0]  s_glyph_row_bits = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_pixel_address;
    logic [7:0]  m_row_pixels;
    logic        m_last_row;
    logic [12:0] m_dirty_right;
    logic [12:0] m_dirty_bottom;

    int          mismatch_count;
    int          rows_outstanding;

    // Stimulus side state
    int          send_idle_pct = 19;
    int          recv_idle_pct = 56;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          items_sent = 0;
    int          cycles = 0;
    logic        cur_enabled;
    int          cur_rows;
    int          cur_width;
    int          cur_height;
    logic [31:0] glyph_loaded [GLYPH_COUNT];

    bitmap_font_console_renderer_unit u_dut (.*);

    bfcr_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Row write receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Timeout
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Rows 0..cur_rows-1 of the glyph have all been loaded
    function automatic bit glyph_ready(logic [7:0] code);
        logic [31:0] mask;
        mask = (cur_rows >= 32) ? '1 : ((32'd1 << cur_rows) - 32'd1);
        return (glyph_loaded[code] & mask) == mask;
    endfunction

    // One request; returns at the edge where it was accepted
    task automatic send_request(bfcr_op_t op, logic [7:0] code, logic [11:0] pos,
                                logic [4:0] row_index, logic [7:0] row_bits);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_opcode          <= op;
        s_char_code       <= code;
        s_position_value  <= pos;
        s_glyph_row_index <= row_index;
        s_glyph_row_bits  <= row_bits;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_LOAD_ROW)
            glyph_loaded[code][row_index] = 1'b1;
        items_sent++;
    endtask

    task automatic put_char(logic [7:0] code);
        send_request(OP_PUT_CHAR, code, 12'($urandom_range(4095)),
                     5'($urandom_range(31)), 8'($urandom_range(255)));
    endtask

    task automatic set_cursor(bfcr_op_t op, logic [11:0] pos);
        send_request(op, 8'($urandom_range(255)), pos,
                     5'($urandom_range(31)), 8'($urandom_range(255)));
    endtask

    task automatic load_row(logic [7:0] code, logic [4:0] row_index, logic [7:0] row_bits);
        send_request(OP_LOAD_ROW, code, 12'($urandom_range(4095)), row_index, row_bits);
    endtask

    // Load every row in use for one glyph, with solid rows now and then
    task automatic load_glyph(logic [7:0] code);
        logic [7:0] row_bits;
        for (int r = 0; r < cur_rows; r++) begin
            case ($urandom_range(5))
                0:       row_bits = 8'h00;
                1:       row_bits = 8'hFF;
                default: row_bits = 8'($urandom_range(255));
            endcase
            load_row(code, 5'(r), row_bits);
        end
    endtask

    // Cursor position near the interesting spots: edges, wrap point, anywhere
    task automatic random_cursor(bfcr_op_t op);
        int bound;
        int pos;
        bound = (op == OP_SET_COL) ? cur_width - GLYPH_WIDTH : cur_height - cur_rows;
        case ($urandom_range(3))
            0:       pos = 0;
            1:       pos = COORD_MAX;
            2:       pos = (bound < 0) ? 0 : (bound > COORD_MAX) ? COORD_MAX : bound;
            default: pos = $urandom_range(COORD_MAX);
        endcase
        set_cursor(op, 12'(pos));
    endtask

    task automatic write_register(logic [2:0] index, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Let the block go quiet, then write all six registers
    task automatic change_settings(logic enabled, logic [5:0] height, logic [12:0] width,
                                   logic [12:0] scr_height, logic [16:0] pitch,
                                   logic [31:0] base);
        s_valid <= 1'b0;
        do @(posedge aclk); while (rows_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_register(REG_CONSOLE_ENABLED, 32'(enabled));
        write_register(REG_GLYPH_HEIGHT, 32'(height));
        write_register(REG_SCREEN_WIDTH, 32'(width));
        write_register(REG_SCREEN_HEIGHT, 32'(scr_height));
        write_register(REG_LINE_PITCH, 32'(pitch));
        write_register(REG_FRAMEBUFFER_BASE, base);
        cfg_valid   <= 1'b0;
        cur_enabled = enabled;
        cur_rows    = (height < 1) ? 1 : (int'(height) > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS
                                                                        : int'(height);
        cur_width   = int'(width);
        cur_height  = int'(scr_height);
    endtask

    // Load-then-put sequences as the largest share, the rest puts of loaded
    // glyphs, newlines, cursor moves and stray loads
    task automatic run_random(int budget);
        int         start;
        int         pick;
        int         repeats;
        logic [7:0] code;
        logic [7:0] probe;
        start = items_sent;
        while (items_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                code = 8'($urandom_range(255));
                load_glyph(code);
                repeats = $urandom_range(1, 3);
                for (int k = 0; k < repeats; k++) begin
                    if ($urandom_range(3) == 0)
                        random_cursor(OP_SET_COL);
                    put_char(code);
                end
            end else if (pick < 62) begin
                // any glyph whose rows are in place; anything goes while disabled
                code = 8'(NEWLINE_CODE);
                for (int t = 0; t < 16; t++) begin
                    probe = 8'($urandom_range(255));
                    if (!cur_enabled || glyph_ready(probe)) begin
                        code = probe;
                        break;
                    end
                end
                put_char(code);
            end else if (pick < 70) begin
                put_char(8'(NEWLINE_CODE));
            end else if (pick < 82) begin
                random_cursor(OP_SET_COL);
            end else if (pick < 92) begin
                random_cursor(OP_SET_LINE);
            end else begin
                load_row(8'($urandom_range(255)), 5'($urandom_range(31)),
                         8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        for (int c = 0; c < GLYPH_COUNT; c++)
            glyph_loaded[c] = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 4-row glyphs on a 32x20 screen, base near the top of memory
        change_settings(1'b1, 6'd4, 13'd32, 13'd20, 17'd4, 32'hFFFF_FFF0);
        load_row(8'd0, 5'd0, 8'h00);
        load_row(8'd0, 5'd1, 8'hFF);
        load_row(8'd0, 5'd2, 8'h80);
        load_row(8'd0, 5'd3, 8'h01);
        load_row(8'd255, 5'd0, 8'hAA);
        load_row(8'd255, 5'd1, 8'h55);
        load_row(8'd255, 5'd2, 8'hFF);
        load_row(8'd255, 5'd3, 8'h00);
        load_row(8'd255, 5'd31, 8'hC3);
        put_char(8'd0);
        put_char(8'd255);
        // column wrap into the next text line
        set_cursor(OP_SET_COL, 12'd24);
        put_char(8'd0);
        // newline wraps the line back to the top
        set_cursor(OP_SET_LINE, 12'd16);
        put_char(8'd255);
        put_char(8'(NEWLINE_CODE));
        // extreme cursor: column past the coordinate limit, rows below the screen
        set_cursor(OP_SET_COL, 12'd4095);
        put_char(8'd0);
        set_cursor(OP_SET_LINE, 12'd4095);
        put_char(8'd255);
        set_cursor(OP_SET_COL, 12'd0);
        set_cursor(OP_SET_LINE, 12'd0);
        put_char(8'd0);

        // Random phases over a spread of settings and idle patterns
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 56;
                recv_idle_pct <= 19;
            end else if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            case (phase)
                0: change_settings(1'b1, 6'd1, 13'd8, 13'd1, 17'd4, 32'h0000_0000);
                1: change_settings(1'b1, 6'd32, 13'd4096, 13'd4096, 17'd65536, 32'hFFFF_FFFF);
                2: change_settings(1'b0, 6'd8, 13'd1024, 13'd768, 17'd4096, 32'h1000_0000);
                3: change_settings(1'b1, 6'd0, 13'd8191, 13'd8191, 17'd131071, 32'h8000_0000);
                4: change_settings(1'b1, 6'd63, 13'd200, 13'd0, 17'd1000, $urandom);
                5: change_settings(1'b1, 6'($urandom_range(1, 12)),
                                   13'($urandom_range(8, 4096)), 13'($urandom_range(1, 4096)),
                                   17'($urandom_range(4, 65536)), $urandom);
                default: change_settings(1'b1, 6'd5, 13'd64, 13'd100, 17'd256, $urandom);
            endcase
            // long output stall while requests keep coming
            if (phase == 6)
                hold_requests <= hold_requests + 1;
            run_random(PHASE_ITEMS);
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (rows_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
sv/bfcr_pkg.sv
sv/bitmap_font_console_renderer_unit.sv
dv/bfcr_checker.sv
dv/tb_bitmap_font_console_renderer_unit.sv
